// ===== rtl/core/gbn_pkg.sv =====
`timescale 1ns / 1ps
package gbn_pkg;
	localparam int WindowMax = 16;
	localparam int SlotW = $clog2(WindowMax);
	localparam int CntW = $clog2(WindowMax + 1);
	localparam logic [19:0] InitialTimeout = 20'd50;
	localparam logic [19:0] TMax = 20'hFFFFF;
	localparam logic [8:0] MaxLen = 9'd497;

	localparam logic [1:0] REQ_OFFER = 2'd0;
	localparam logic [1:0] REQ_ACK = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	localparam logic [2:0] EV_SEND = 3'd0;
	localparam logic [2:0] EV_RETX = 3'd1;
	localparam logic [2:0] EV_FULL = 3'd2;
	localparam logic [2:0] EV_ACK = 3'd3;
	localparam logic [2:0] EV_IDLE = 3'd4;
	localparam logic [2:0] EV_ABORT = 3'd5;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_DYN = 2'd1;
	localparam logic [1:0] REG_STATIC = 2'd2;
	localparam logic [1:0] REG_RETRIES = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [31:0] ack_seq;
		logic [15:0] seg_handle;
		logic [8:0] seg_length;
	} req_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [31:0] tx_seq;
		logic [15:0] tx_handle;
		logic [8:0] tx_length;
		logic [31:0] window_base;
		logic [19:0] current_timeout;
		logic last;
	} res_t;
endpackage

// ===== rtl/core/gbn_front.sv =====
`timescale 1ns / 1ps
// input skid register in front of the engine
module gbn_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gbn_pkg::req_t in_req,
	output logic q_valid,
	input logic q_take,
	output gbn_pkg::req_t q_req
);
	logic [1:0] cnt_q;
	gbn_pkg::req_t buf_q [2];
	logic wr_q, rd_q;
	logic push;

	assign in_stall = cnt_q == 2'd2;
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign q_req = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_req;
	end
endmodule

// ===== rtl/core/gbn_engine.sv =====
`timescale 1ns / 1ps
module gbn_engine (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_take,
	input gbn_pkg::req_t q_req,
	input logic [4:0] win_size,
	input logic dyn_en,
	input logic [19:0] static_timeout,
	input logic [3:0] max_retries,
	output logic out_valid,
	input logic out_stall,
	output gbn_pkg::res_t out_res
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RTT1 = 3'd1;
	localparam logic [2:0] ST_RTT2 = 3'd2;
	localparam logic [2:0] ST_RETX = 3'd3;
	localparam logic [2:0] ST_RD = 3'd4;

	logic [2:0] st_q;
	logic [31:0] base_q, next_q;
	logic [15:0] mem_h [gbn_pkg::WindowMax];
	logic [8:0] mem_l [gbn_pkg::WindowMax];
	logic [15:0] rd_h_q;
	logic [8:0] rd_l_q;
	logic timer_run_q, samp_q, abort_q;
	logic [19:0] telap_q, tout_q, relap_q;
	logic [23:0] est_q, dev_q;
	logic [3:0] retry_q;
	logic [31:0] rseq_q;
	logic [gbn_pkg::CntW-1:0] rleft_q;
	logic [25:0] a_q;

	logic [19:0] tif;
	logic [gbn_pkg::CntW-1:0] effw;
	logic [31:0] outst;
	logic can_out;
	logic [19:0] e;
	logic [31:0] cnt;
	logic rtt_go, retx_go;

	assign tif = dyn_en ? tout_q : (static_timeout == '0 ? 20'd1 : static_timeout);
	assign effw = win_size == '0 ? gbn_pkg::CntW'(1) :
		(32'(win_size) > gbn_pkg::WindowMax ? gbn_pkg::CntW'(gbn_pkg::WindowMax) :
		gbn_pkg::CntW'(win_size));
	assign outst = next_q - base_q;
	assign can_out = !out_valid || !out_stall;
	assign e = telap_q + 20'd1;
	assign cnt = outst > gbn_pkg::WindowMax ? 32'(gbn_pkg::WindowMax) : outst;
	assign q_take = st_q == ST_IDLE && q_valid && can_out;
	assign rtt_go = !abort_q && q_req.req_type == gbn_pkg::REQ_ACK &&
		q_req.ack_seq - base_q < outst && dyn_en && samp_q;
	assign retx_go = !abort_q && q_req.req_type == gbn_pkg::REQ_TICK && timer_run_q &&
		(e > tif || e == '0) && retry_q < max_retries && cnt != '0;

	logic [25:0] s_w, est_w, d1;
	logic [25:0] dn;
	logic [26:0] tsum;
	always_comb begin
		s_w = {3'b0, relap_q, 3'b0};
		d1 = s_w - {2'b0, est_q};
		est_w = {2'b0, est_q} + {{3{d1[25]}}, d1[25:3]};
		dn = a_q - {2'b0, dev_q};
		tsum = 27'(est_q) + {1'b0, dev_q, 2'b0} + 27'd7;
	end

	task automatic emit(input logic [2:0] k, input logic [31:0] sq, input logic [15:0] h,
			input logic [8:0] l, input logic [31:0] b, input logic [19:0] t, input logic ls);
		out_res.event_kind <= k;
		out_res.tx_seq <= sq;
		out_res.tx_handle <= h;
		out_res.tx_length <= l;
		out_res.window_base <= b;
		out_res.current_timeout <= t;
		out_res.last <= ls;
	endtask

	always_ff @(posedge clk) begin
		if (q_take && !abort_q && q_req.req_type == gbn_pkg::REQ_OFFER &&
				outst < 32'(effw)) begin
			mem_h[next_q[gbn_pkg::SlotW-1:0]] <= q_req.seg_handle;
			mem_l[next_q[gbn_pkg::SlotW-1:0]] <=
				q_req.seg_length > gbn_pkg::MaxLen ? gbn_pkg::MaxLen : q_req.seg_length;
		end
		rd_h_q <= mem_h[rseq_q[gbn_pkg::SlotW-1:0]];
		rd_l_q <= mem_l[rseq_q[gbn_pkg::SlotW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			base_q <= '0;
			next_q <= '0;
			timer_run_q <= 1'b0;
			samp_q <= 1'b0;
			abort_q <= 1'b0;
			telap_q <= '0;
			tout_q <= gbn_pkg::InitialTimeout;
			relap_q <= '0;
			est_q <= '0;
			dev_q <= '0;
			retry_q <= '0;
			rseq_q <= '0;
			rleft_q <= '0;
			a_q <= '0;
			out_valid <= 1'b0;
			out_res <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (q_take) begin
					out_valid <= !(rtt_go || retx_go);
					if (abort_q) begin
						emit(gbn_pkg::EV_ABORT, '0, '0, '0, base_q, tif, 1'b1);
					end else if (q_req.req_type == gbn_pkg::REQ_OFFER) begin
						if (outst < 32'(effw)) begin
							if (dyn_en && !samp_q) begin
								samp_q <= 1'b1;
								relap_q <= '0;
							end
							if (base_q == next_q) begin
								timer_run_q <= 1'b1;
								telap_q <= '0;
							end
							next_q <= next_q + 32'd1;
							emit(gbn_pkg::EV_SEND, next_q, q_req.seg_handle,
								q_req.seg_length > gbn_pkg::MaxLen ? gbn_pkg::MaxLen :
								q_req.seg_length, base_q, tif, 1'b1);
						end else begin
							emit(gbn_pkg::EV_FULL, '0, '0, '0, base_q, tif, 1'b1);
						end
					end else if (q_req.req_type == gbn_pkg::REQ_ACK) begin
						if (q_req.ack_seq - base_q < outst) begin
							base_q <= q_req.ack_seq + 32'd1;
							retry_q <= '0;
							telap_q <= '0;
							timer_run_q <= q_req.ack_seq + 32'd1 != next_q;
							if (dyn_en && samp_q) begin
								samp_q <= 1'b0;
								st_q <= ST_RTT1;
								est_q <= est_w[25] ? '0 : est_w[23:0];
								a_q <= s_w < est_w ? est_w - s_w : s_w - est_w;
							end
							emit(gbn_pkg::EV_ACK, '0, '0, '0, q_req.ack_seq + 32'd1, tif, 1'b1);
						end else begin
							emit(gbn_pkg::EV_IDLE, '0, '0, '0, base_q, tif, 1'b1);
						end
					end else if (q_req.req_type == gbn_pkg::REQ_TICK) begin
						if (samp_q && relap_q != gbn_pkg::TMax) relap_q <= relap_q + 20'd1;
						if (!timer_run_q) begin
							emit(gbn_pkg::EV_IDLE, '0, '0, '0, base_q, tif, 1'b1);
						end else if (e > tif || e == '0) begin
							if (retry_q >= max_retries) begin
								abort_q <= 1'b1;
								timer_run_q <= 1'b0;
								emit(gbn_pkg::EV_ABORT, '0, '0, '0, base_q, tif, 1'b1);
							end else begin
								retry_q <= retry_q + 4'd1;
								telap_q <= '0;
								if (dyn_en) begin
									tout_q <= tout_q[19] ? gbn_pkg::TMax : {tout_q[18:0], 1'b0};
									if (!samp_q) begin
										samp_q <= 1'b1;
										relap_q <= '0;
									end
								end
								if (cnt == '0) begin
									emit(gbn_pkg::EV_IDLE, '0, '0, '0, base_q,
										dyn_en ? (tout_q[19] ? gbn_pkg::TMax :
										{tout_q[18:0], 1'b0}) : tif, 1'b1);
								end else begin
									rseq_q <= base_q;
									rleft_q <= gbn_pkg::CntW'(cnt);
									st_q <= ST_RD;
								end
							end
						end else begin
							telap_q <= e;
							emit(gbn_pkg::EV_IDLE, '0, '0, '0, base_q, tif, 1'b1);
						end
					end else begin
						emit(gbn_pkg::EV_IDLE, '0, '0, '0, base_q, tif, 1'b1);
					end
				end else if (out_valid && !out_stall) begin
					out_valid <= 1'b0;
				end
				ST_RTT1: begin
					dev_q <= 24'({2'b0, dev_q} + {{2{dn[25]}}, dn[25:2]});
					st_q <= ST_RTT2;
				end
				ST_RTT2: begin
					tout_q <= tsum[26:3] > 24'(gbn_pkg::TMax) ? gbn_pkg::TMax :
						(tsum[26:3] == '0 ? 20'd1 : tsum[22:3]);
					out_res.current_timeout <= tsum[26:3] > 24'(gbn_pkg::TMax) ?
						gbn_pkg::TMax : (tsum[26:3] == '0 ? 20'd1 : tsum[22:3]);
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_RD: begin
					if (out_valid && !out_stall) out_valid <= 1'b0;
					st_q <= ST_RETX;
				end
				ST_RETX: if (can_out) begin
					out_valid <= 1'b1;
					emit(gbn_pkg::EV_RETX, rseq_q, rd_h_q, rd_l_q, base_q, tif,
						rleft_q == gbn_pkg::CntW'(1));
					rseq_q <= rseq_q + 32'd1;
					rleft_q <= rleft_q - gbn_pkg::CntW'(1);
					st_q <= rleft_q == gbn_pkg::CntW'(1) ? ST_IDLE : ST_RD;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
// Go-Back-N sender window. Offers, acks and ticks enter through a two-entry
// queue; offers, stale acks and plain ticks give one result in the cycle after
// the engine takes them, an ack closing an RTT sample runs the estimator states
// RTT1 and RTT2, and an expiry emits one retransmit per outstanding slot, each
// via ST_RD's registered slot-memory read and ST_RETX. Registers: 0x0 window
// size, 0x4 dynamic_timeout_enable, 0x8 static_timeout, 0xc max_retries.
module go_back_n_sender_window (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] req_type,
	input logic [31:0] ack_seq,
	input logic [15:0] seg_handle,
	input logic [8:0] seg_length,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] event_kind,
	output logic [31:0] tx_seq,
	output logic [15:0] tx_handle,
	output logic [8:0] tx_length,
	output logic [31:0] window_base,
	output logic [19:0] current_timeout,
	output logic last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [4:0] win_q;
	logic dyn_q;
	logic [19:0] stat_q;
	logic [3:0] retr_q;
	gbn_pkg::req_t in_req, q_req;
	gbn_pkg::res_t res;
	logic q_valid, q_take;

	assign pready = 1'b1;
	assign in_req = '{req_type: req_type, ack_seq: ack_seq, seg_handle: seg_handle,
		seg_length: seg_length};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 5'd16;
			dyn_q <= 1'b1;
			stat_q <= 20'd50;
			retr_q <= 4'd10;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				gbn_pkg::REG_WINDOW: win_q <= pwdata[4:0];
				gbn_pkg::REG_DYN: dyn_q <= pwdata[0];
				gbn_pkg::REG_STATIC: stat_q <= pwdata[19:0];
				gbn_pkg::REG_RETRIES: retr_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gbn_pkg::REG_WINDOW: prdata = {27'b0, win_q};
			gbn_pkg::REG_DYN: prdata = {31'b0, dyn_q};
			gbn_pkg::REG_STATIC: prdata = {12'b0, stat_q};
			gbn_pkg::REG_RETRIES: prdata = {28'b0, retr_q};
			default: prdata = '0;
		endcase
	end

	gbn_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_req, .q_valid, .q_take, .q_req);

	gbn_engine u_engine (.clk, .arst_n, .q_valid, .q_take, .q_req, .win_size(win_q),
		.dyn_en(dyn_q), .static_timeout(stat_q), .max_retries(retr_q), .out_valid,
		.out_stall, .out_res(res));

	assign event_kind = res.event_kind;
	assign tx_seq = res.tx_seq;
	assign tx_handle = res.tx_handle;
	assign tx_length = res.tx_length;
	assign window_base = res.window_base;
	assign current_timeout = res.current_timeout;
	assign last = res.last;
endmodule

// ===== rtl/core/gbn_checker.sv =====
`timescale 1ns / 1ps
module gbn_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] event_kind,
	input logic [31:0] window_base,
	input logic [19:0] current_timeout
);
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) &&
		$stable(window_base) && $stable(current_timeout))
		else $error("stalled item changed");
	ap_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_kind <= 3'd5) else $error("bad kind");
	ap_tout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_timeout != 20'd0) else $error("zero timeout");
endmodule

bind go_back_n_sender_window gbn_checker u_chk (.clk, .arst_n, .out_valid, .out_stall,
	.event_kind, .window_base, .current_timeout);
